FILE: hw/rtl/u8sv_pkg.sv
// ----------------------------------------------------------------------------
// u8sv_pkg
// Shared constants and helpers for the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package u8sv_pkg;

  // Position counter width default
  localparam int POSITION_BITS = 32;

  // Result position width on the output channel
  localparam int ERR_POS_W = 32;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] ADDR_PRINTABLE_MODE = 3'd0;

  // Lead byte ranges
  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;

  // Leads that narrow the first continuation byte
  localparam logic [7:0] LEAD_E0 = 8'hE0;
  localparam logic [7:0] LEAD_ED = 8'hED;
  localparam logic [7:0] LEAD_F0 = 8'hF0;
  localparam logic [7:0] LEAD_F4 = 8'hF4;

  localparam logic [7:0] CONT_LO     = 8'h80;
  localparam logic [7:0] CONT_HI     = 8'hBF;
  localparam logic [7:0] CONT_E0_LO  = 8'hA0;
  localparam logic [7:0] CONT_ED_HI  = 8'h9F;
  localparam logic [7:0] CONT_F0_LO  = 8'h90;
  localparam logic [7:0] CONT_F4_HI  = 8'h8F;

  // Printable set
  localparam logic [7:0]  ASCII_TAB   = 8'h09;
  localparam logic [7:0]  ASCII_LF    = 8'h0A;
  localparam logic [7:0]  ASCII_CR    = 8'h0D;
  localparam logic [7:0]  ASCII_SP    = 8'h20;
  localparam logic [7:0]  ASCII_TILDE = 8'h7E;
  localparam logic [20:0] CP_NEL      = 21'h000085;
  localparam logic [20:0] CP_NBSP     = 21'h0000A0;
  localparam logic [20:0] CP_BMP_MAX  = 21'h00FFFD;
  localparam logic [20:0] CP_SUPP_LO  = 21'h010000;

  function automatic logic ascii_printable(input logic [7:0] b);
    return (b == ASCII_TAB) || (b == ASCII_LF) || (b == ASCII_CR) ||
           ((b >= ASCII_SP) && (b <= ASCII_TILDE));
  endfunction

  function automatic logic code_point_printable(input logic [20:0] cp);
    return (cp == CP_NEL) || ((cp >= CP_NBSP) && (cp <= CP_BMP_MAX)) ||
           (cp >= CP_SUPP_LO);
  endfunction

endpackage

FILE: hw/rtl/utf8_stream_validator_core.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator_core
// Checks a byte stream for UTF-8 well-formedness, optionally c-printable.
// ----------------------------------------------------------------------------
// Input channel: one byte per request (in_data_byte) with in_last_byte on the
//   final byte of a stream. A request is taken when in_valid is high and
//   in_stall is low.
// Output channel: one request per stream, out_well_formed plus
//   out_error_position (first bad byte offset, 0 when well formed), taken
//   when out_valid is high and out_stall is low. After an error the result
//   goes out once found (a bad continuation byte at the end of its sequence)
//   and the rest of the stream up to its last byte is dropped silently.
// Path: input register, then the check logic into the result register, which
//   raises out_valid; out_stall can hold a byte in the input register.
// Throughput: one byte per cycle when out_stall holds no result; the check
//   is a single stage of compare logic against the stream state registers.
// Stall: while a result waits in the output register under out_stall, a byte
//   in the input register holds and in_stall is high; nothing is lost.
// Reset: rst_n (synchronous) empties both registers, clears the stream state
//   and clears printable_mode. The user must write configuration over the APB
//   port only while no stream is in flight; the core does not enforce this.
// ----------------------------------------------------------------------------
module utf8_stream_validator_core #(
  parameter int POSITION_BITS = u8sv_pkg::POSITION_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_last_byte,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_well_formed,
  output logic [u8sv_pkg::ERR_POS_W-1:0]   out_error_position,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [u8sv_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [u8sv_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [u8sv_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam logic [POSITION_BITS-1:0] PosMax = '1;
  localparam logic [POSITION_BITS-1:0] PosOne = {{(POSITION_BITS-1){1'b0}}, 1'b1};

  // configuration
  logic mode_r;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // stream state
  logic [POSITION_BITS-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]               lead_byte_r, lead_byte_nxt;
  logic [1:0]               cont_left_r, cont_left_nxt;
  logic [1:0]               cont_idx_r, cont_idx_nxt;
  logic [20:0]              cp_r, cp_nxt;
  logic [POSITION_BITS-1:0] lead_pos_r, lead_pos_nxt;
  logic                     pend_err_r, pend_err_nxt;
  logic [POSITION_BITS-1:0] pend_pos_r, pend_pos_nxt;
  logic                     discard_r, discard_nxt;

  // result register
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_wf_r;
  logic [u8sv_pkg::ERR_POS_W-1:0]   out_pos_r;

  logic                             out_free;
  logic                             step;
  logic                             res_valid;
  logic                             res_wf;
  logic [POSITION_BITS-1:0]         res_pos;
  logic [u8sv_pkg::ERR_POS_W-1:0]   res_pos_out;

  logic       err;
  logic       bad_cont;
  logic [7:0] lo, hi;
  logic [7:0] b;

  assign out_free = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  assign out_valid          = out_valid_r;
  assign out_well_formed    = out_wf_r;
  assign out_error_position = out_pos_r;

  assign pready = 1'b1;
  assign prdata = (paddr == u8sv_pkg::ADDR_PRINTABLE_MODE) ?
                  {{(u8sv_pkg::CFG_DATA_W-1){1'b0}}, mode_r} : '0;

  generate
    if (POSITION_BITS >= u8sv_pkg::ERR_POS_W) begin : g_pos_trunc
      assign res_pos_out = res_pos[u8sv_pkg::ERR_POS_W-1:0];
    end else begin : g_pos_ext
      assign res_pos_out = {{(u8sv_pkg::ERR_POS_W-POSITION_BITS){1'b0}}, res_pos};
    end
  endgenerate

  // per-byte check
  always_comb begin
    b              = s1_byte_r;
    byte_count_nxt = byte_count_r;
    lead_byte_nxt  = lead_byte_r;
    cont_left_nxt  = cont_left_r;
    cont_idx_nxt   = cont_idx_r;
    cp_nxt         = cp_r;
    lead_pos_nxt   = lead_pos_r;
    pend_err_nxt   = pend_err_r;
    pend_pos_nxt   = pend_pos_r;
    discard_nxt    = discard_r;
    err            = 1'b0;
    res_valid      = 1'b0;
    res_wf         = 1'b0;
    res_pos        = '0;
    lo             = u8sv_pkg::CONT_LO;
    hi             = u8sv_pkg::CONT_HI;
    bad_cont       = 1'b0;

    if (step) begin
      if (discard_r) begin
        // drop until the end of the stream
        if (s1_last_r) begin
          discard_nxt = 1'b0;
        end
      end else begin
        if (byte_count_r != PosMax) begin
          byte_count_nxt = byte_count_r + PosOne;
        end

        if (cont_left_r != 2'd0) begin
          if (cont_idx_r == 2'd1) begin
            case (lead_byte_r)
              u8sv_pkg::LEAD_E0: lo = u8sv_pkg::CONT_E0_LO;
              u8sv_pkg::LEAD_ED: hi = u8sv_pkg::CONT_ED_HI;
              u8sv_pkg::LEAD_F0: lo = u8sv_pkg::CONT_F0_LO;
              u8sv_pkg::LEAD_F4: hi = u8sv_pkg::CONT_F4_HI;
              default: ;
            endcase
          end
          bad_cont = (b < lo) || (b > hi);
          if (bad_cont && !pend_err_r) begin
            pend_err_nxt = 1'b1;
            pend_pos_nxt = byte_count_r;
          end
          cp_nxt        = {cp_r[14:0], b[5:0]};
          cont_left_nxt = cont_left_r - 2'd1;
          cont_idx_nxt  = cont_idx_r + 2'd1;
          if (cont_left_r == 2'd1) begin
            if (pend_err_nxt) begin
              err     = 1'b1;
              res_pos = pend_pos_nxt;
            end else if (mode_r && !u8sv_pkg::code_point_printable(cp_nxt)) begin
              err     = 1'b1;
              res_pos = lead_pos_r;
            end
            pend_err_nxt = 1'b0;
            pend_pos_nxt = '0;
            cont_idx_nxt = 2'd0;
          end
        end else if (!b[7]) begin
          if (mode_r && !u8sv_pkg::ascii_printable(b)) begin
            err     = 1'b1;
            res_pos = byte_count_r;
          end
        end else if ((b >= u8sv_pkg::LEAD2_LO) && (b <= u8sv_pkg::LEAD4_HI)) begin
          lead_byte_nxt = b;
          lead_pos_nxt  = byte_count_r;
          cont_idx_nxt  = 2'd1;
          pend_err_nxt  = 1'b0;
          pend_pos_nxt  = '0;
          if (b <= u8sv_pkg::LEAD2_HI) begin
            cont_left_nxt = 2'd1;
            cp_nxt        = {16'd0, b[4:0]};
          end else if (b <= u8sv_pkg::LEAD3_HI) begin
            cont_left_nxt = 2'd2;
            cp_nxt        = {17'd0, b[3:0]};
          end else begin
            cont_left_nxt = 2'd3;
            cp_nxt        = {18'd0, b[2:0]};
          end
        end else begin
          // stray continuation or invalid lead
          err     = 1'b1;
          res_pos = byte_count_r;
        end

        // stream ends inside a sequence: report its lead
        if (!err && s1_last_r && (cont_left_nxt != 2'd0)) begin
          err     = 1'b1;
          res_pos = lead_pos_nxt;
        end

        if (err) begin
          res_valid = 1'b1;
          res_wf    = 1'b0;
          if (!s1_last_r) begin
            discard_nxt = 1'b1;
          end
        end else if (s1_last_r) begin
          res_valid = 1'b1;
          res_wf    = 1'b1;
          res_pos   = '0;
        end
      end

      if (s1_last_r) begin
        byte_count_nxt = '0;
        lead_byte_nxt  = '0;
        cont_left_nxt  = '0;
        cont_idx_nxt   = '0;
        cp_nxt         = '0;
        lead_pos_nxt   = '0;
        pend_err_nxt   = 1'b0;
        pend_pos_nxt   = '0;
        discard_nxt    = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = res_valid;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 1'b0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      byte_count_r <= '0;
      lead_byte_r  <= '0;
      cont_left_r  <= '0;
      cont_idx_r   <= '0;
      cp_r         <= '0;
      lead_pos_r   <= '0;
      pend_err_r   <= 1'b0;
      pend_pos_r   <= '0;
      discard_r    <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready &&
          (paddr == u8sv_pkg::ADDR_PRINTABLE_MODE)) begin
        mode_r <= pwdata[0];
      end
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      out_valid_r  <= out_valid_nxt;
      byte_count_r <= byte_count_nxt;
      lead_byte_r  <= lead_byte_nxt;
      cont_left_r  <= cont_left_nxt;
      cont_idx_r   <= cont_idx_nxt;
      cp_r         <= cp_nxt;
      lead_pos_r   <= lead_pos_nxt;
      pend_err_r   <= pend_err_nxt;
      pend_pos_r   <= pend_pos_nxt;
      discard_r    <= discard_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (out_free && res_valid) begin
      out_wf_r  <= res_wf;
      out_pos_r <= res_pos_out;
    end
  end

endmodule
